// File: rtl/vnorm_pkg.sv
// vnorm_pkg: shared types and constants for the vector normalize pipeline.
// No dependencies.
package vnorm_pkg;

  localparam int unsigned LATENCY = 67;

  typedef struct packed {
    logic            vld;
    logic            zero;
    logic [2:0]      neg;
    logic [2:0][31:0] mag;
  } tag_t;

  typedef struct packed {
    tag_t        tag;
    logic [63:0] rad;
    logic [34:0] rem;
    logic [31:0] root;
  } sqrt_t;

  typedef struct packed {
    logic             vld;
    logic             zero;
    logic [2:0]       neg;
    logic [31:0]      len;
    logic [2:0][32:0] rem;
    logic [2:0][30:0] quo;
  } div_t;

endpackage

// File: rtl/vector3_normalize.sv
// vector3_normalize: length and unit vector of one Q16.16 vector per cycle.
// Depends on vnorm_pkg, vnorm_sqrt_cell, vnorm_div_cell.
//
//   channel  handshake       payload
//   in       start / busy    in_x_in, in_y_in, in_z_in
//   out      out_valid       out_length, out_x_unit, out_y_unit, out_z_unit, out_zero_error
//
// One vector per cycle; busy stays low. Pipeline registers in order: input,
// square, sum, 32 square-root cells, 31 divider cells, output register.
// Synchronous reset clears the valid bits only. Results cannot be stalled.
module vector3_normalize (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_x_in,
  input  logic [31:0] in_y_in,
  input  logic [31:0] in_z_in,
  output logic        out_valid,
  output logic [31:0] out_length,
  output logic [31:0] out_x_unit,
  output logic [31:0] out_y_unit,
  output logic [31:0] out_z_unit,
  output logic        out_zero_error
);

  vnorm_pkg::tag_t  s0_r, s0_nxt, s1_r, s1_nxt;
  logic [2:0][63:0] sq_r;
  vnorm_pkg::sqrt_t s2_r, s2_nxt;
  vnorm_pkg::sqrt_t sq_c [0:32];
  vnorm_pkg::div_t  dv_c [0:31];
  logic [2:0][31:0] in_v;
  logic [2:0][31:0] unit_nxt;
  logic        out_valid_r;
  logic [31:0] out_length_r, out_x_r, out_y_r, out_z_r;
  logic        out_zero_r;

  assign busy = 1'b0;
  assign in_v = {in_z_in, in_y_in, in_x_in};

  always_comb begin
    s0_nxt.vld  = start;
    s0_nxt.zero = (in_x_in == '0) && (in_y_in == '0) && (in_z_in == '0);
    for (int k = 0; k < 3; k++) begin
      s0_nxt.neg[k] = in_v[k][31];
      s0_nxt.mag[k] = in_v[k][31] ? (~in_v[k] + 32'd1) : in_v[k];
    end
    if (!rst_n) begin
      s0_nxt.vld = 1'b0;
    end
  end

  always_comb begin
    s1_nxt = s0_r;
    if (!rst_n) begin
      s1_nxt.vld = 1'b0;
    end
  end

  always_comb begin
    s2_nxt.tag  = s1_r;
    s2_nxt.rad  = sq_r[0] + sq_r[1] + sq_r[2];
    s2_nxt.rem  = '0;
    s2_nxt.root = '0;
    if (!rst_n) begin
      s2_nxt.tag.vld = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    s0_r <= s0_nxt;
    s1_r <= s1_nxt;
    for (int k = 0; k < 3; k++) begin
      sq_r[k] <= {32'd0, s0_r.mag[k]} * {32'd0, s0_r.mag[k]};
    end
    s2_r <= s2_nxt;
  end

  assign sq_c[0] = s2_r;

  for (genvar i = 0; i < 32; i++) begin : g_sqrt
    vnorm_sqrt_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .d_i  (sq_c[i]),
      .d_o  (sq_c[i+1])
    );
  end

  always_comb begin
    dv_c[0].vld  = sq_c[32].tag.vld;
    dv_c[0].zero = sq_c[32].tag.zero;
    dv_c[0].neg  = sq_c[32].tag.neg;
    dv_c[0].len  = sq_c[32].root;
    dv_c[0].quo  = '0;
    for (int k = 0; k < 3; k++) begin
      dv_c[0].rem[k] = {1'b0, sq_c[32].tag.mag[k]};
    end
  end

  for (genvar i = 0; i < 31; i++) begin : g_div
    vnorm_div_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .d_i  (dv_c[i]),
      .d_o  (dv_c[i+1])
    );
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      unit_nxt[k] = dv_c[31].neg[k] ? (~{1'b0, dv_c[31].quo[k]} + 32'd1)
                                    : {1'b0, dv_c[31].quo[k]};
      if (dv_c[31].zero) begin
        unit_nxt[k] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_length_r <= dv_c[31].zero ? 32'd0 : dv_c[31].len;
    out_x_r      <= unit_nxt[0];
    out_y_r      <= unit_nxt[1];
    out_z_r      <= unit_nxt[2];
    out_zero_r   <= dv_c[31].zero;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_c[31].vld;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_length     = out_length_r;
  assign out_x_unit     = out_x_r;
  assign out_y_unit     = out_y_r;
  assign out_z_unit     = out_z_r;
  assign out_zero_error = out_zero_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##67 out_valid)
    else $error("beat lost in pipeline");

  a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_error) |->
      (out_length == '0 && out_x_unit == '0 && out_y_unit == '0 && out_z_unit == '0))
    else $error("zero vector gave nonzero result");

  a_len_nz: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_zero_error) |-> (out_length != '0))
    else $error("nonzero vector gave zero length");

  a_unit_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_x_unit) <= 32'sd1073741824 &&
                   $signed(out_x_unit) >= -32'sd1073741824))
    else $error("unit component out of range");

endmodule

// File: rtl/vnorm_sqrt_cell.sv
// vnorm_sqrt_cell: one root bit of the digit-recurrence square root.
// Depends on vnorm_pkg.
module vnorm_sqrt_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  vnorm_pkg::sqrt_t d_i,
  output vnorm_pkg::sqrt_t d_o
);

  vnorm_pkg::sqrt_t d_r, d_nxt;
  logic [34:0] rem_sh;
  logic [34:0] trial;

  always_comb begin
    d_nxt = d_i;
    rem_sh = {d_i.rem[32:0], d_i.rad[63:62]};
    trial  = {1'b0, d_i.root, 2'b01};
    d_nxt.rad = {d_i.rad[61:0], 2'b00};
    if (rem_sh >= trial) begin
      d_nxt.rem  = rem_sh - trial;
      d_nxt.root = {d_i.root[30:0], 1'b1};
    end else begin
      d_nxt.rem  = rem_sh;
      d_nxt.root = {d_i.root[30:0], 1'b0};
    end
    if (!rst_n) begin
      d_nxt.tag.vld = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
  end

  assign d_o = d_r;

endmodule

// File: rtl/vnorm_div_cell.sv
// vnorm_div_cell: one quotient bit of three restoring divisions by the length.
// Depends on vnorm_pkg.
module vnorm_div_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  vnorm_pkg::div_t d_i,
  output vnorm_pkg::div_t d_o
);

  vnorm_pkg::div_t d_r, d_nxt;
  logic [2:0][32:0] diff;
  logic [2:0]       ge;
  logic [2:0][31:0] rout;

  always_comb begin
    d_nxt = d_i;
    for (int k = 0; k < 3; k++) begin
      diff[k] = d_i.rem[k] - {1'b0, d_i.len};
      ge[k]   = d_i.rem[k] >= {1'b0, d_i.len};
      rout[k] = ge[k] ? diff[k][31:0] : d_i.rem[k][31:0];
      d_nxt.rem[k] = {rout[k], 1'b0};
      d_nxt.quo[k] = {d_i.quo[k][29:0], ge[k]};
    end
    if (!rst_n) begin
      d_nxt.vld = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
  end

  assign d_o = d_r;

endmodule

// File: dv/vector3_normalize_test.sv
// vector3_normalize_test: self-checking testbench for vector3_normalize.
// Drives directed and random vectors, predicts length and unit vector in software.
// Depends on vector3_normalize and vnorm_pkg.
module vector3_normalize_test;

  localparam int N_RANDOM = 1200;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic [31:0] length;
    logic [31:0] x_unit;
    logic [31:0] y_unit;
    logic [31:0] z_unit;
    logic        zero_error;
  } norm_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    bit          typed;
    norm_t       res;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] in_x_in = '0;
  logic [31:0] in_y_in = '0;
  logic [31:0] in_z_in = '0;
  logic        out_valid;
  logic [31:0] out_length;
  logic [31:0] out_x_unit;
  logic [31:0] out_y_unit;
  logic [31:0] out_z_unit;
  logic        out_zero_error;

  norm_t  pending_norms[$];
  int     errors = 0;
  longint cycles = 0;
  row_t   rows[$];

  always #6 clk = ~clk;

  vector3_normalize DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_x_in(in_x_in), .in_y_in(in_y_in), .in_z_in(in_z_in),
    .out_valid(out_valid), .out_length(out_length), .out_x_unit(out_x_unit),
    .out_y_unit(out_y_unit), .out_z_unit(out_z_unit), .out_zero_error(out_zero_error)
  );

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic norm_t normalize(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    norm_t n;
    logic [31:0] c[3];
    logic [63:0] m[3];
    logic [63:0] sum;
    logic [63:0] len;
    logic [63:0] q;
    c[0] = x;
    c[1] = y;
    c[2] = z;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = c[i][31] ? 64'h1_0000_0000 - {32'd0, c[i]} : {32'd0, c[i]};
      sum = sum + m[i] * m[i];
    end
    n = '{default: '0};
    if (sum == 0) begin
      n.zero_error = 1'b1;
      return n;
    end
    len = root64(sum);
    n.length = len[31:0];
    for (int i = 0; i < 3; i++) begin
      q = (m[i] << 30) / len;
      if (c[i][31]) q = -q;
      case (i)
        0: n.x_unit = q[31:0];
        1: n.y_unit = q[31:0];
        default: n.z_unit = q[31:0];
      endcase
    end
    return n;
  endfunction

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'd0;
      3: return $urandom_range(3) - 1;
      4: return {{16{1'b0}}, 16'($urandom)};
      5: return {{16{1'b1}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function automatic void add_row(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                  bit typed, norm_t res);
    row_t r;
    r.x = x;
    r.y = y;
    r.z = z;
    r.typed = typed;
    r.res = res;
    rows.push_back(r);
  endfunction

  task automatic idle_gap();
    int n;
    n = 0;
    case ($urandom_range(9))
      0, 1, 2: n = $urandom_range(3, 1);
      3: n = $urandom_range(80, 20);
      default: n = 0;
    endcase
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic send_vector(logic [31:0] x, logic [31:0] y, logic [31:0] z, norm_t res);
    start <= 1'b1;
    in_x_in <= x;
    in_y_in <= y;
    in_z_in <= z;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_norms.push_back(res);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    norm_t e;
    if (rst_n && out_valid) begin
      if (pending_norms.size() == 0) begin
        $error("result beat with no vector pending");
        errors++;
      end else begin
        e = pending_norms.pop_front();
        if (out_length !== e.length) begin
          $error("length exp %h got %h", e.length, out_length);
          errors++;
        end
        if (out_x_unit !== e.x_unit) begin
          $error("x_unit exp %h got %h", e.x_unit, out_x_unit);
          errors++;
        end
        if (out_y_unit !== e.y_unit) begin
          $error("y_unit exp %h got %h", e.y_unit, out_y_unit);
          errors++;
        end
        if (out_z_unit !== e.z_unit) begin
          $error("z_unit exp %h got %h", e.z_unit, out_z_unit);
          errors++;
        end
        if (out_zero_error !== e.zero_error) begin
          $error("zero_error exp %b got %b", e.zero_error, out_zero_error);
          errors++;
        end
      end
    end
  end

  initial begin
    norm_t zero_res;
    norm_t one_x;
    norm_t neg_y;
    norm_t min_z;
    norm_t res;
    int waited;
    zero_res = '{default: '0};
    zero_res.zero_error = 1'b1;
    one_x = '{32'h0001_0000, 32'h4000_0000, 32'd0, 32'd0, 1'b0};
    neg_y = '{32'h0001_0000, 32'd0, 32'hC000_0000, 32'd0, 1'b0};
    min_z = '{32'h8000_0000, 32'd0, 32'd0, 32'hC000_0000, 1'b0};

    add_row(32'd0, 32'd0, 32'd0, 1, zero_res);
    add_row(32'h0001_0000, 32'd0, 32'd0, 1, one_x);
    add_row(32'd0, 32'hFFFF_0000, 32'd0, 1, neg_y);
    add_row(32'd0, 32'd0, 32'h8000_0000, 1, min_z);
    add_row(32'd1, 32'd0, 32'd0, 0, zero_res);
    add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, zero_res);
    add_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, zero_res);
    add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, zero_res);
    add_row(32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 0, zero_res);
    add_row(32'h0003_0000, 32'h0004_0000, 32'd0, 0, zero_res);
    add_row(32'd0, 32'd0, 32'd1, 0, zero_res);
    add_row(32'h8000_0000, 32'd1, 32'hFFFF_FFFF, 0, zero_res);
    add_row(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 0, zero_res);
    add_row(32'd0, 32'd0, 32'd0, 1, zero_res);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      res = rows[i].typed ? rows[i].res : normalize(rows[i].x, rows[i].y, rows[i].z);
      send_vector(rows[i].x, rows[i].y, rows[i].z, res);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      if (i % 200 < 60) idle_gap();
      else if (i % 200 > 150) idle_gap();
      x = rand_comp();
      y = rand_comp();
      z = rand_comp();
      send_vector(x, y, z, normalize(x, y, z));
    end
    start <= 1'b0;

    waited = 0;
    while (pending_norms.size() != 0 && waited < 10 * vnorm_pkg::LATENCY) begin
      @(posedge clk);
      waited++;
    end
    repeat (vnorm_pkg::LATENCY + 8) @(posedge clk);
    if (errors == 0 && pending_norms.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
